// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication or plain property sampled on the clock, off while in reset.
`define ASSERT_CLK(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition that must never be true outside reset.
`define ASSERT_NEVER(name, clk, rst, cond, msg) \
   name: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// ----- rtl/bdq_pkg.sv -----
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared constants, codes and controller/datapath types of the deque.
// ----------------------------------------------------------------------------
package bdq_pkg;

   localparam int BDQ_DEPTH = 64;
   localparam int DATA_W    = 32;
   localparam int OP_W      = 3;
   localparam int STATUS_W  = 2;
   localparam int POS_W     = 7;

   // Operation codes.
   localparam logic [OP_W-1:0] OP_PUSH_TAIL = 3'd0;
   localparam logic [OP_W-1:0] OP_PUSH_HEAD = 3'd1;
   localparam logic [OP_W-1:0] OP_DROP_HEAD = 3'd2;
   localparam logic [OP_W-1:0] OP_DROP_TAIL = 3'd3;
   localparam logic [OP_W-1:0] OP_CLEAR     = 3'd4;
   localparam logic [OP_W-1:0] OP_DUMP      = 3'd5;

   // Result status codes.
   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

   // Pointer update codes from controller to datapath.
   localparam logic [2:0] UPD_NONE      = 3'd0;
   localparam logic [2:0] UPD_PUSH_TAIL = 3'd1;
   localparam logic [2:0] UPD_PUSH_HEAD = 3'd2;
   localparam logic [2:0] UPD_DROP_HEAD = 3'd3;
   localparam logic [2:0] UPD_DROP_TAIL = 3'd4;
   localparam logic [2:0] UPD_CLEAR     = 3'd5;

   typedef struct packed {
      logic                load_rsp;
      logic                dump_word;
      logic [STATUS_W-1:0] status;
      logic                last;
      logic [2:0]          upd;
      logic                rd_en;
   } bdq_cmd_type;

   typedef struct packed {
      logic empty;
      logic full;
      logic out_free;
   } bdq_stat_type;

endpackage

// ----- rtl/bdq_if.sv -----
// ----------------------------------------------------------------------------
// bdq_if
// Valid/ready channels for requests and responses of the deque.
// ----------------------------------------------------------------------------
interface bdq_req_if import bdq_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [OP_W-1:0]          op;
   logic signed [DATA_W-1:0] value;

   modport source (output valid, output op, output value, input ready);
   modport sink   (input valid, input op, input value, output ready);
endinterface

interface bdq_rsp_if import bdq_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [STATUS_W-1:0]      status;
   logic signed [DATA_W-1:0] element;
   logic [POS_W-1:0]         position;
   logic                     last;

   modport source (output valid, output status, output element, output position,
                   output last, input ready);
   modport sink   (input valid, input status, input element, input position,
                   input last, output ready);
endinterface

// ----- rtl/bdq_dpath.sv -----
// ----------------------------------------------------------------------------
// bdq_dpath
// Element store, head/count registers and the response output register.
// ----------------------------------------------------------------------------
module bdq_dpath import bdq_pkg::*; #(
   parameter  int DEPTH = BDQ_DEPTH,
   localparam int IDX_W = $clog2(DEPTH),
   localparam int CNT_W = $clog2(DEPTH + 1)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  bdq_cmd_type              cmd,
   input  logic [IDX_W-1:0]         rd_offset,
   input  logic [IDX_W-1:0]         dump_idx,
   input  logic signed [DATA_W-1:0] push_value,
   output bdq_stat_type             stat,
   output logic [CNT_W-1:0]         count,
   bdq_rsp_if.source                rsp
);

   logic signed [DATA_W-1:0] mem [DEPTH];
   logic signed [DATA_W-1:0] rd_data_ff;

   logic [IDX_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0] count_ff, count_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]      rsp_status_ff;
   logic signed [DATA_W-1:0] rsp_element_ff;
   logic [POS_W-1:0]         rsp_position_ff;
   logic                     rsp_last_ff;

   logic [IDX_W:0]   rd_sum, tail_sum;
   logic [IDX_W-1:0] rd_slot, tail_slot, head_dec, head_inc;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;

   // Slot of element k is (head + k) mod DEPTH; both terms are below DEPTH.
   always_comb begin
      rd_sum   = {1'b0, head_ff} + {1'b0, rd_offset};
      tail_sum = {1'b0, head_ff} + {1'b0, count_ff[IDX_W-1:0]};
      rd_slot  = (rd_sum >= (IDX_W+1)'(DEPTH)) ?
                 IDX_W'(rd_sum - (IDX_W+1)'(DEPTH)) : rd_sum[IDX_W-1:0];
      tail_slot = (tail_sum >= (IDX_W+1)'(DEPTH)) ?
                  IDX_W'(tail_sum - (IDX_W+1)'(DEPTH)) : tail_sum[IDX_W-1:0];
      head_dec = (head_ff == '0) ? IDX_W'(DEPTH - 1) : head_ff - IDX_W'(1);
      head_inc = (head_ff == IDX_W'(DEPTH - 1)) ? '0 : head_ff + IDX_W'(1);
   end

   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      wr_en    = 1'b0;
      wr_addr  = tail_slot;
      case (cmd.upd)
         UPD_PUSH_TAIL: begin
            wr_en    = 1'b1;
            count_in = count_ff + CNT_W'(1);
         end
         UPD_PUSH_HEAD: begin
            wr_en    = 1'b1;
            wr_addr  = head_dec;
            head_in  = head_dec;
            count_in = count_ff + CNT_W'(1);
         end
         UPD_DROP_HEAD: begin
            head_in  = head_inc;
            count_in = count_ff - CNT_W'(1);
         end
         UPD_DROP_TAIL: begin
            count_in = count_ff - CNT_W'(1);
         end
         UPD_CLEAR: begin
            head_in  = '0;
            count_in = '0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= push_value;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem[rd_slot];
      end
   end

   // Output register: a new word may load in the cycle the old one is taken.
   assign stat.out_free = !rsp_valid_ff || rsp.ready;
   assign stat.empty    = (count_ff == '0);
   assign stat.full     = (count_ff == CNT_W'(DEPTH));
   assign count         = count_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_status_ff <= cmd.status;
         rsp_last_ff   <= cmd.last;
         if (cmd.dump_word) begin
            rsp_element_ff  <= rd_data_ff;
            rsp_position_ff <= POS_W'(dump_idx) + POS_W'(1);
         end else begin
            rsp_element_ff  <= '0;
            rsp_position_ff <= '0;
         end
      end
   end

   assign rsp.valid    = rsp_valid_ff;
   assign rsp.status   = rsp_status_ff;
   assign rsp.element  = rsp_element_ff;
   assign rsp.position = rsp_position_ff;
   assign rsp.last     = rsp_last_ff;

endmodule

// ----- rtl/bdq_ctrl.sv -----
// ----------------------------------------------------------------------------
// bdq_ctrl
// Request decode and dump sequencer of the deque.
// ----------------------------------------------------------------------------
module bdq_ctrl import bdq_pkg::*; #(
   parameter  int DEPTH = BDQ_DEPTH,
   localparam int IDX_W = $clog2(DEPTH),
   localparam int CNT_W = $clog2(DEPTH + 1)
) (
   input  logic             clock,
   input  logic             reset,
   bdq_req_if.sink          req,
   input  bdq_stat_type     stat,
   input  logic [CNT_W-1:0] count,
   output bdq_cmd_type      cmd,
   output logic [IDX_W-1:0] rd_offset,
   output logic [IDX_W-1:0] dump_idx
);

   localparam logic S_IDLE = 1'b0;
   localparam logic S_DUMP = 1'b1;

   logic             state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             accept;
   logic             dump_last;

   assign req.ready = (state_ff == S_IDLE) && stat.out_free;
   assign accept    = req.valid && req.ready;
   assign dump_last = (CNT_W'(idx_ff) + CNT_W'(1)) == count;
   assign dump_idx  = idx_ff;

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      rd_offset     = idx_ff;
      cmd.load_rsp  = 1'b0;
      cmd.dump_word = 1'b0;
      cmd.status    = ST_OK;
      cmd.last      = 1'b1;
      cmd.upd       = UPD_NONE;
      cmd.rd_en     = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.load_rsp = 1'b1;
               case (req.op)
                  OP_PUSH_TAIL, OP_PUSH_HEAD: begin
                     if (stat.full) begin
                        cmd.status = ST_FULL;
                     end else begin
                        cmd.upd = (req.op == OP_PUSH_TAIL) ? UPD_PUSH_TAIL
                                                           : UPD_PUSH_HEAD;
                     end
                  end
                  OP_DROP_HEAD, OP_DROP_TAIL, OP_CLEAR: begin
                     if (stat.empty) begin
                        cmd.status = ST_EMPTY;
                     end else if (req.op == OP_DROP_HEAD) begin
                        cmd.upd = UPD_DROP_HEAD;
                     end else if (req.op == OP_DROP_TAIL) begin
                        cmd.upd = UPD_DROP_TAIL;
                     end else begin
                        cmd.upd = UPD_CLEAR;
                     end
                  end
                  OP_DUMP: begin
                     if (stat.empty) begin
                        cmd.status = ST_EMPTY;
                     end else begin
                        // Fetch the head element; words follow from the dump state.
                        cmd.load_rsp = 1'b0;
                        cmd.rd_en    = 1'b1;
                        rd_offset    = '0;
                        idx_in       = '0;
                        state_in     = S_DUMP;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_DUMP: begin
            if (stat.out_free) begin
               cmd.load_rsp  = 1'b1;
               cmd.dump_word = 1'b1;
               cmd.last      = dump_last;
               if (dump_last) begin
                  state_in = S_IDLE;
               end else begin
                  idx_in    = idx_ff + IDX_W'(1);
                  rd_offset = idx_ff + IDX_W'(1);
                  cmd.rd_en = 1'b1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

endmodule

// ----- rtl/bounded_deque.sv -----
// ----------------------------------------------------------------------------
// bounded_deque
// Bounded double-ended queue of signed 32-bit words in a circular store.
// ----------------------------------------------------------------------------
// Requests arrive on req_chan (op, value) and responses leave on rsp_chan
// (status, element, position, last); both use a valid/ready handshake.
// Push at tail or head, drop from head or tail, and clear each give one
// response word in the cycle after the request is accepted. A dump streams
// every stored element from head to tail, one word per cycle while the
// receiver takes each; a dump holds the request side until its last word loads.
// Pushing into a full queue gives status full; dropping, clearing or dumping
// an empty queue gives status empty; the final word of every request has last
// set. The response register frees in the cycle its word is taken, so with no
// stall simple requests are taken every cycle. The dump rate is set by the
// single registered read port of the store. When the receiver stalls, the
// response word holds and no new request is taken. Reset empties the queue at
// once; the store contents are not cleared.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bounded_deque import bdq_pkg::*; #(
   parameter int DEPTH = BDQ_DEPTH
) (
   input  logic      clock,
   input  logic      reset,
   bdq_req_if.sink   req_chan,
   bdq_rsp_if.source rsp_chan
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   bdq_cmd_type      cmd;
   bdq_stat_type     stat;
   logic [CNT_W-1:0] count;
   logic [IDX_W-1:0] rd_offset;
   logic [IDX_W-1:0] dump_idx;

   logic             req_take;
   logic             push_take;
   logic             dump_take;
   logic [CNT_W-1:0] count_inc;
   logic             mid_word;
   logic             dump_shape;

   bdq_ctrl #(.DEPTH(DEPTH)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req       (req_chan),
      .stat      (stat),
      .count     (count),
      .cmd       (cmd),
      .rd_offset (rd_offset),
      .dump_idx  (dump_idx)
   );

   bdq_dpath #(.DEPTH(DEPTH)) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .rd_offset  (rd_offset),
      .dump_idx   (dump_idx),
      .push_value (req_chan.value),
      .stat       (stat),
      .count      (count),
      .rsp        (rsp_chan)
   );

   assign req_take   = req_chan.valid && req_chan.ready;
   assign push_take  = req_take && !stat.full &&
                       (req_chan.op == OP_PUSH_TAIL || req_chan.op == OP_PUSH_HEAD);
   assign dump_take  = req_take && !stat.empty && (req_chan.op == OP_DUMP);
   assign count_inc  = count + CNT_W'(1);
   assign mid_word   = rsp_chan.valid && !rsp_chan.last;
   assign dump_shape = (rsp_chan.status == ST_OK) && (rsp_chan.position != '0);

   `ASSERT_NEVER(a_count_bound, clock, reset, count > CNT_W'(DEPTH), "count above depth")
   `ASSERT_CLK(a_push_counts, clock, reset, push_take |=> count == $past(count_inc), "push lost")
   `ASSERT_CLK(a_dump_holds, clock, reset, dump_take |=> !req_chan.ready, "taken during dump")
   `ASSERT_CLK(a_mid_word, clock, reset, mid_word |-> dump_shape, "bad non-final word")

endmodule

// ----- tb/sv/deque_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deque_checker
// Watches the request and response channels of the deque, keeps its own copy
// of the queue contents, and compares every response word with the words that
// the accepted requests call for, field by field and in order.
// ----------------------------------------------------------------------------
module deque_checker import bdq_pkg::*; (
   input  logic clock,
   input  logic reset,
   bdq_req_if   req_mon,
   bdq_rsp_if   rsp_mon,
   output int   fail_count,
   output int   pending
);

   typedef struct {
      logic [STATUS_W-1:0]      status;
      logic signed [DATA_W-1:0] element;
      logic [POS_W-1:0]         position;
      logic                     last;
   } rsp_word_type;

   rsp_word_type             expected_words[$];
   logic signed [DATA_W-1:0] slots[BDQ_DEPTH];
   logic [5:0]               head_slot;
   logic [6:0]               fill;

   initial begin
      fail_count = 0;
      pending    = 0;
      head_slot  = '0;
      fill       = '0;
   end

   function void expect_word(logic [STATUS_W-1:0] status, logic signed [DATA_W-1:0] element,
                             logic [POS_W-1:0] position, logic last);
      rsp_word_type w;
      w.status   = status;
      w.element  = element;
      w.position = position;
      w.last     = last;
      expected_words.push_back(w);
   endfunction

   // Updates the copy of the queue for one request and queues the words it gives.
   function void apply_request(logic [OP_W-1:0] op, logic signed [DATA_W-1:0] value);
      logic [5:0] slot;
      case (op)
         OP_PUSH_TAIL, OP_PUSH_HEAD: begin
            if (fill == BDQ_DEPTH) begin
               expect_word(ST_FULL, '0, '0, 1'b1);
            end else begin
               if (op == OP_PUSH_HEAD) begin
                  head_slot = head_slot - 6'd1;
                  slot      = head_slot;
               end else begin
                  slot = 6'(head_slot + fill);
               end
               slots[slot] = value;
               fill        = fill + 7'd1;
               expect_word(ST_OK, '0, '0, 1'b1);
            end
         end
         OP_DROP_HEAD, OP_DROP_TAIL, OP_CLEAR: begin
            if (fill == 0) begin
               expect_word(ST_EMPTY, '0, '0, 1'b1);
            end else begin
               if (op == OP_CLEAR) begin
                  fill      = '0;
                  head_slot = '0;
               end else begin
                  if (op == OP_DROP_HEAD) head_slot = head_slot + 6'd1;
                  fill = fill - 7'd1;
               end
               expect_word(ST_OK, '0, '0, 1'b1);
            end
         end
         OP_DUMP: begin
            if (fill == 0) begin
               expect_word(ST_EMPTY, '0, '0, 1'b1);
            end else begin
               for (int k = 0; k < fill; k++) begin
                  slot = 6'(head_slot + k);
                  expect_word(ST_OK, slots[slot], POS_W'(k + 1), (k + 1 == fill));
               end
            end
         end
         // The spare op codes leave the queue alone and answer ok.
         default: expect_word(ST_OK, '0, '0, 1'b1);
      endcase
   endfunction

   function void check_field(string name, logic signed [63:0] expv, logic signed [63:0] actv);
      if (expv !== actv) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, expv, actv);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      rsp_word_type w;
      if (reset) begin
         expected_words.delete();
         head_slot = '0;
         fill      = '0;
      end else begin
         // Responses first: a response never belongs to a request taken on the same edge.
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_words.size() == 0) begin
               $display("%0t: response word with none expected, actual status %0d element %0d",
                        $time, rsp_mon.status, rsp_mon.element);
               fail_count++;
            end else begin
               w = expected_words.pop_front();
               check_field("status", w.status, rsp_mon.status);
               check_field("element", w.element, rsp_mon.element);
               check_field("position", w.position, rsp_mon.position);
               check_field("last", w.last, rsp_mon.last);
            end
         end
         if (req_mon.valid && req_mon.ready) apply_request(req_mon.op, req_mon.value);
      end
      pending = expected_words.size();
   end

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the deque with a short directed sequence and then with fill, drain
// and mixed traffic with random values, under random gaps on both channels.
// A checker beside the block predicts and compares every response word.
// ----------------------------------------------------------------------------
module tb_top;
   import bdq_pkg::*;

   typedef enum {MODE_FILL, MODE_DRAIN, MODE_MIXED} traffic_mode_type;

   // Op codes that the block does not define.
   localparam logic [OP_W-1:0] OP_SPARE_A = 3'd6;
   localparam logic [OP_W-1:0] OP_SPARE_B = 3'd7;

   localparam int REQUEST_TARGET = 470;

   logic clock = 1'b0;
   logic reset;
   int   fail_count;
   int   pending;
   bit   quiet = 1'b0;
   int   stall_left = 0;

   bdq_req_if req_chan();
   bdq_rsp_if rsp_chan();

   bounded_deque dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   deque_checker chk (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_chan),
      .rsp_mon    (rsp_chan),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always #5 clock = ~clock;

   // Mostly no gap, some short ones, a few long ones.
   function int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 40);
   endfunction

   function logic signed [DATA_W-1:0] pick_value();
      if ($urandom_range(0, 9) != 0) return $urandom;
      case ($urandom_range(0, 3))
         0:       return 32'sh8000_0000;
         1:       return 32'sh7FFF_FFFF;
         2:       return 32'sh0;
         default: return -32'sd1;
      endcase
   endfunction

   function logic [OP_W-1:0] pick_op(traffic_mode_type mode);
      int r;
      r = $urandom_range(0, 99);
      case (mode)
         MODE_FILL: begin
            if (r < 48) return OP_PUSH_TAIL;
            if (r < 88) return OP_PUSH_HEAD;
            if (r < 92) return OP_DROP_HEAD;
            if (r < 95) return OP_DROP_TAIL;
            if (r < 98) return OP_DUMP;
            if (r < 99) return OP_CLEAR;
         end
         MODE_DRAIN: begin
            if (r < 15) return OP_PUSH_TAIL;
            if (r < 25) return OP_PUSH_HEAD;
            if (r < 55) return OP_DROP_HEAD;
            if (r < 85) return OP_DROP_TAIL;
            if (r < 92) return OP_DUMP;
            if (r < 96) return OP_CLEAR;
         end
         default: begin
            if (r < 25) return OP_PUSH_TAIL;
            if (r < 45) return OP_PUSH_HEAD;
            if (r < 62) return OP_DROP_HEAD;
            if (r < 79) return OP_DROP_TAIL;
            if (r < 90) return OP_DUMP;
            if (r < 94) return OP_CLEAR;
         end
      endcase
      return $urandom_range(0, 1) ? OP_SPARE_A : OP_SPARE_B;
   endfunction

   // Presents one request word and returns at the edge that takes it.
   task issue_request(logic [OP_W-1:0] op, logic signed [DATA_W-1:0] value);
      int gap;
      gap = quiet ? 0 : pick_gap();
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.op    <= op;
      req_chan.value <= value;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   task wait_for_drain();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      wait (pending == 0);
      @(posedge clock);
   endtask

   // Receiver side: random stalls; no new stall starts while the traffic is in a quiet stretch.
   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_chan.ready <= 1'b0;
         stall_left--;
      end else begin
         rsp_chan.ready <= 1'b1;
         if (!quiet && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
   end

   initial begin
      #80_000_000;
      $display("Some tests failed");
      $finish;
   end

   initial begin
      traffic_mode_type mode;
      int               sent;
      int               seg_len;
      reset          = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.op    = OP_PUSH_TAIL;
      req_chan.value = '0;
      rsp_chan.ready = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Drops, clear and dump on an empty queue, then the spare codes.
      issue_request(OP_DROP_HEAD, 32'sd5);
      issue_request(OP_DROP_TAIL, -32'sd5);
      issue_request(OP_CLEAR, 32'sd0);
      issue_request(OP_DUMP, 32'sd0);
      issue_request(OP_SPARE_A, -32'sd1);
      issue_request(OP_SPARE_B, 32'sh7FFF_FFFF);
      // Value extremes at both ends.
      issue_request(OP_PUSH_TAIL, 32'sh7FFF_FFFF);
      issue_request(OP_PUSH_HEAD, 32'sh8000_0000);
      issue_request(OP_PUSH_TAIL, 32'sd0);
      issue_request(OP_PUSH_HEAD, -32'sd1);
      issue_request(OP_DUMP, 32'sd0);
      issue_request(OP_DROP_HEAD, 32'sd0);
      issue_request(OP_DROP_TAIL, 32'sd0);
      issue_request(OP_DUMP, 32'sd0);
      issue_request(OP_CLEAR, 32'sd0);
      issue_request(OP_DUMP, 32'sd0);
      // A head push into an empty queue wraps the head to the top slot.
      issue_request(OP_PUSH_HEAD, 32'sh1234_5678);
      issue_request(OP_PUSH_TAIL, -32'sh1234_5678);
      issue_request(OP_DUMP, 32'sd0);
      issue_request(OP_DROP_TAIL, 32'sd0);
      // Emptying from the head must leave the tail consistent for the next push.
      issue_request(OP_DROP_HEAD, 32'sd0);
      issue_request(OP_PUSH_TAIL, 32'sh0F0F_0F0F);
      issue_request(OP_DUMP, 32'sd0);
      issue_request(OP_CLEAR, 32'sd0);
      wait_for_drain();

      // Fill past the limit so that pushes get refused, then dump a full queue.
      quiet = 1'b1;
      for (int i = 0; i < 70; i++) begin
         issue_request($urandom_range(0, 1) ? OP_PUSH_TAIL : OP_PUSH_HEAD, pick_value());
      end
      quiet = 1'b0;
      issue_request(OP_DUMP, pick_value());
      sent = 95;

      while (sent < REQUEST_TARGET) begin
         mode    = traffic_mode_type'($urandom_range(0, 2));
         seg_len = $urandom_range(20, 90);
         if (seg_len > REQUEST_TARGET - sent) seg_len = REQUEST_TARGET - sent;
         quiet   = ($urandom_range(0, 3) == 0);
         repeat (seg_len) begin
            issue_request(pick_op(mode), pick_value());
            sent++;
         end
         if ($urandom_range(0, 2) == 0) wait_for_drain();
      end
      quiet = 1'b0;
      wait_for_drain();

      repeat (20) @(posedge clock);
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
